/* rtl/cba_pkg.sv */
// ----------------------------------------------------------------------------
// cba_pkg
// shared types and constants of the contiguous block allocator
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = 11;
  localparam int START_W    = 10;
  localparam int FIRST_W    = 10;
  localparam int SUM_W      = CNT_W + 1;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t               command;
    logic [CNT_W-1:0]   blk_count;
    logic [START_W-1:0] start_block;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [FIRST_W-1:0] first_block;
  } out_item_t;

  // write port of the map memory
  typedef struct packed {
    logic               en;
    logic [WADDR_W-1:0] addr;
    logic [WORD_W-1:0]  data;
  } ram_wr_t;

  // result of searching one map word
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
    logic [CNT_W-1:0] run_top;
  } search_t;

endpackage

/* rtl/cba_map_ram.sv */
// ----------------------------------------------------------------------------
// cba_map_ram
// usage map storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module cba_map_ram (
  input  logic                          clk,
  input  cba_pkg::ram_wr_t              wr,
  input  logic [cba_pkg::WADDR_W-1:0]   rd_addr,
  output logic [cba_pkg::WORD_W-1:0]    rd_data_r
);
  import cba_pkg::*;

  logic [WORD_W-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* rtl/cba_word_search.sv */
// ----------------------------------------------------------------------------
// cba_word_search
// finds the lowest bit of one map word where the free run reaches the need
// ----------------------------------------------------------------------------
module cba_word_search (
  input  logic [cba_pkg::WORD_W-1:0] word,
  input  logic [cba_pkg::CNT_W-1:0]  run_in,
  input  logic [cba_pkg::CNT_W-1:0]  need,
  output cba_pkg::search_t           res
);
  import cba_pkg::*;

  always_comb begin
    logic             found;
    logic [BIT_W-1:0] lu;
    logic [CNT_W-1:0] run_j;
    found = 1'b0;
    lu    = '0;
    run_j = '0;
    res   = '0;
    // downward so that the lowest hit wins
    for (int j = WORD_W - 1; j >= 0; j--) begin
      found = 1'b0;
      lu    = '0;
      // last used bit at or below j
      for (int k = 0; k <= j; k++) begin
        if (word[k]) begin
          found = 1'b1;
          lu    = BIT_W'(k);
        end
      end
      if (word[j]) begin
        run_j = '0;
      end else if (found) begin
        run_j = CNT_W'(j) - CNT_W'(lu);
      end else begin
        run_j = run_in + CNT_W'(j + 1);
      end
      if (j == WORD_W - 1) begin
        res.run_top = run_j;
      end
      if (run_j >= need) begin
        res.hit = 1'b1;
        res.pos = BIT_W'(j);
      end
    end
  end

endmodule

/* rtl/contiguous_block_allocator_core.sv */
// ----------------------------------------------------------------------------
// contiguous_block_allocator_core
// first-fit allocator of contiguous block runs over a one-bit-per-block map
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  input     in_item (command, count, start) start high while busy low
//  result    out_item (status, first_block)  out_valid for one cycle
//
//  the map sits in a 32-word by 32-bit memory with a registered read port
//  allocate: a scan of the map words from word 0, then a read-modify-write pass marking the run
//  free: a read-modify-write of each touched word, clearing the run
//  a bad request answers in the cycle after the transaction, busy stays low
//  after reset a clearing pass zeroes every map word with busy high
//  the receiver cannot stall, each result shows for exactly one cycle
// ----------------------------------------------------------------------------
module contiguous_block_allocator_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  cba_pkg::in_item_t  in_item,
  output logic               out_valid,
  output cba_pkg::out_item_t out_item
);
  import cba_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK
  } state_t;

  state_t               state_r;
  logic [WADDR_W-1:0]   clr_addr_r;
  logic [WADDR_W-1:0]   iss_addr_r;   // word address being read
  logic                 iss_done_r;   // every needed word has been read
  logic                 pend_r;       // read data valid this cycle
  logic [WADDR_W-1:0]   pend_addr_r;  // word address of the read data
  logic [CNT_W-1:0]     run_r;        // free run carried from lower words
  logic [CNT_W-1:0]     need_r;
  logic [IDX_W-1:0]     lo_r;         // first block of the run to update
  logic [IDX_W-1:0]     last_r;       // last block of the run to update
  logic                 set_r;        // mark used, otherwise clear
  logic [FIRST_W-1:0]   first_r;
  logic                 out_valid_r;
  out_item_t            out_item_r;

  ram_wr_t              wr;
  logic [WORD_W-1:0]    rd_data_r;
  search_t              sr;

  logic [SUM_W-1:0]     free_end;
  logic [SUM_W-1:0]     hit_start;
  logic [IDX_W-1:0]     hit_idx;
  logic [WADDR_W-1:0]   lo_w;
  logic [WADDR_W-1:0]   last_w;
  logic [BIT_W-1:0]     lb;
  logic [BIT_W-1:0]     ub;
  logic [WORD_W-1:0]    mask;

  cba_map_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_addr   (iss_addr_r),
    .rd_data_r (rd_data_r)
  );

  cba_word_search u_search (
    .word   (rd_data_r),
    .run_in (run_r),
    .need   (need_r),
    .res    (sr)
  );

  // exclusive end of a free range
  assign free_end  = SUM_W'(in_item.start_block) + SUM_W'(in_item.blk_count);
  // block where the found run ends and where it starts
  assign hit_idx   = {pend_addr_r, sr.pos};
  assign hit_start = SUM_W'(hit_idx) + SUM_W'(1) - SUM_W'(need_r);

  // bit mask of the run inside the word in flight
  assign lo_w   = lo_r[IDX_W-1:BIT_W];
  assign last_w = last_r[IDX_W-1:BIT_W];
  assign lb     = (pend_addr_r == lo_w)   ? lo_r[BIT_W-1:0]   : '0;
  assign ub     = (pend_addr_r == last_w) ? last_r[BIT_W-1:0] : '1;
  assign mask   = ({WORD_W{1'b1}} << lb) &
                  ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - ub));

  // memory writes: zero words while clearing, read-modify-write while marking
  always_comb begin
    wr = '0;
    if (state_r == S_CLEAR) begin
      wr.en   = 1'b1;
      wr.addr = clr_addr_r;
      wr.data = '0;
    end else if (state_r == S_MARK && pend_r) begin
      wr.en   = 1'b1;
      wr.addr = pend_addr_r;
      wr.data = set_r ? (rd_data_r | mask) : (rd_data_r & ~mask);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      iss_done_r  <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + WADDR_W'(1);
          if (clr_addr_r == WADDR_W'(NUM_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            iss_done_r <= 1'b0;
            pend_r     <= 1'b0;
            if (in_item.command == CMD_ALLOC) begin
              if (in_item.blk_count == '0 ||
                  in_item.blk_count > CNT_W'(NUM_BLOCKS)) begin
                out_valid_r <= 1'b1;
                out_item_r  <= '{status: ST_BAD, first_block: '0};
              end else begin
                state_r    <= S_SCAN;
                iss_addr_r <= '0;
                run_r      <= '0;
                need_r     <= in_item.blk_count;
              end
            end else begin
              if (in_item.blk_count == '0 ||
                  free_end > SUM_W'(NUM_BLOCKS)) begin
                out_valid_r <= 1'b1;
                out_item_r  <= '{status: ST_BAD, first_block: '0};
              end else begin
                state_r    <= S_MARK;
                lo_r       <= IDX_W'(in_item.start_block);
                last_r     <= IDX_W'(free_end - SUM_W'(1));
                iss_addr_r <= in_item.start_block[IDX_W-1:BIT_W];
                set_r      <= 1'b0;
                first_r    <= '0;
              end
            end
          end
        end

        S_SCAN: begin
          // stream word reads, one per cycle
          pend_r      <= !iss_done_r;
          pend_addr_r <= iss_addr_r;
          if (!iss_done_r) begin
            if (iss_addr_r == WADDR_W'(NUM_WORDS - 1)) begin
              iss_done_r <= 1'b1;
            end else begin
              iss_addr_r <= iss_addr_r + WADDR_W'(1);
            end
          end
          if (pend_r) begin
            if (sr.hit) begin
              // run found: go back and mark it, later reads are dropped
              state_r    <= S_MARK;
              lo_r       <= hit_start[IDX_W-1:0];
              last_r     <= hit_idx;
              iss_addr_r <= hit_start[IDX_W-1:BIT_W];
              iss_done_r <= 1'b0;
              pend_r     <= 1'b0;
              set_r      <= 1'b1;
              first_r    <= hit_start[FIRST_W-1:0];
            end else begin
              run_r <= sr.run_top;
              if (pend_addr_r == WADDR_W'(NUM_WORDS - 1)) begin
                state_r     <= S_IDLE;
                out_valid_r <= 1'b1;
                out_item_r  <= '{status: ST_NOSPACE, first_block: '0};
              end
            end
          end
        end

        S_MARK: begin
          // each word is read once and written the cycle after, while the next word is read
          pend_r      <= !iss_done_r;
          pend_addr_r <= iss_addr_r;
          if (!iss_done_r) begin
            if (iss_addr_r == last_w) begin
              iss_done_r <= 1'b1;
            end else begin
              iss_addr_r <= iss_addr_r + WADDR_W'(1);
            end
          end
          if (pend_r && pend_addr_r == last_w) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            out_item_r  <= '{status: ST_OK, first_block: first_r};
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* rtl/cba_checker.sv */
// ----------------------------------------------------------------------------
// cba_checker
// port-level checks of the contiguous block allocator
// ----------------------------------------------------------------------------
module cba_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input cba_pkg::in_item_t  in_item,
  input logic               out_valid,
  input cba_pkg::out_item_t out_item
);
  import cba_pkg::*;

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && out_item.status != ST_OK |-> out_item.first_block == '0)
    else $error("first_block nonzero on a failed result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> (out_item.status == ST_OK || out_item.status == ST_NOSPACE ||
                     out_item.status == ST_BAD))
    else $error("status code out of range");

  a_zero_count_bad: assert property (@(posedge clk) disable iff (!rst_n)
      start && !busy && in_item.blk_count == '0
      |=> out_valid && out_item.status == ST_BAD && !busy)
    else $error("zero count not rejected at once");

  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
      start && !busy && in_item.command == CMD_ALLOC && in_item.blk_count != '0 &&
      in_item.blk_count <= CNT_W'(NUM_BLOCKS) |=> busy && !out_valid)
    else $error("valid allocate did not start a scan");

endmodule

bind contiguous_block_allocator_core cba_checker u_cba_checker (.*);
